>>> sv/led_strip_animation_frame_defines.svh
// Assertion macros used by the checker file of the LED strip animation block.
`ifndef LED_STRIP_ANIMATION_FRAME_DEFINES_SVH
`define LED_STRIP_ANIMATION_FRAME_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LSAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsaf check failed");

// Antecedent implies consequent in the next cycle.
`define LSAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsaf check failed");

`endif

>>> sv/lsaf_pkg.sv
// Shared types, constants and lookup functions of the LED strip animation block.
package lsaf_pkg;

    localparam int NUM_LEDS     = 18;
    localparam int LEDS_PER_EAR = 9;
    localparam int PIX_W        = 6;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ANIM_MODE      = 3'd0;
    localparam logic [2:0] CFG_BASE_RGB       = 3'd1;
    localparam logic [2:0] CFG_BASE_LEVEL     = 3'd2;
    localparam logic [2:0] CFG_MOUTH_LINK     = 3'd3;
    localparam logic [2:0] CFG_METER_SELECT   = 3'd4;
    localparam logic [2:0] CFG_MOOD_LINK      = 3'd5;
    localparam logic [2:0] CFG_RAINBOW_PERIOD = 3'd6;

    // Animation modes.
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_SOLID   = 2'd1;
    localparam logic [1:0] MODE_BREATH  = 2'd2;
    localparam logic [1:0] MODE_RAINBOW = 2'd3;

    localparam logic [3:0] MOOD_RAINBOW = 4'd12;
    localparam logic [3:0] MOOD_UNUSED  = 4'd15;

    typedef struct packed {
        logic [1:0]  anim_mode;
        logic [23:0] base_rgb;
        logic [7:0]  base_level;
        logic        mouth_link;
        logic        meter_select;
        logic        mood_link;
        logic [7:0]  rainbow_period;
    } t_cfg;

    // One frame job handed from the front end to the pixel engine.
    typedef struct packed {
        logic        rainbow;
        logic [23:0] color;
        logic [7:0]  gain;
        logic [15:0] h0;
        logic        meter;
        logic [2:0]  level;
    } t_job;

    typedef struct packed {
        logic [23:0] rgb;
        logic [14:0] period;
        logic [7:0]  floor8;
    } t_mood;

    function automatic t_mood mood_entry(input logic [3:0] idx);
        t_mood e;
        case (idx)
            4'd0:    e = '{24'hFFD2A0, 15'd4000, 8'd77};
            4'd1:    e = '{24'hFFC800, 15'd2200, 8'd90};
            4'd2:    e = '{24'h2850FF, 15'd5000, 8'd51};
            4'd3:    e = '{24'hFF1E00, 15'd1200, 8'd102};
            4'd4:    e = '{24'hFF8200, 15'd3500, 8'd77};
            4'd5:    e = '{24'h5A008C, 15'd6000, 8'd26};
            4'd6:    e = '{24'h00BEFF, 15'd1600, 8'd90};
            4'd7:    e = '{24'hFFFF5A, 15'd2000, 8'd77};
            4'd8:    e = '{24'hFF0096, 15'd1400, 8'd102};
            4'd9:    e = '{24'h00FFAA, 15'd2800, 8'd77};
            4'd10:   e = '{24'hAA46FF, 15'd3000, 8'd77};
            4'd11:   e = '{24'hFFFFFF, 15'd1000, 8'd115};
            4'd12:   e = '{24'hFFFFFF, 15'd1000, 8'd77};
            4'd13:   e = '{24'hFF5A82, 15'd2400, 8'd90};
            4'd14:   e = '{24'h6E6E6E, 15'd5500, 8'd38};
            default: e = '{24'hFFD2A0, 15'd4000, 8'd77};
        endcase
        return e;
    endfunction

    function automatic logic [8:0] quarter_sine(input logic [6:0] j);
        logic [8:0] v;
        case (j)
            7'd0: v = 9'd0;     7'd1: v = 9'd6;     7'd2: v = 9'd13;    7'd3: v = 9'd19;
            7'd4: v = 9'd25;    7'd5: v = 9'd31;    7'd6: v = 9'd38;    7'd7: v = 9'd44;
            7'd8: v = 9'd50;    7'd9: v = 9'd56;    7'd10: v = 9'd62;   7'd11: v = 9'd68;
            7'd12: v = 9'd74;   7'd13: v = 9'd80;   7'd14: v = 9'd86;   7'd15: v = 9'd92;
            7'd16: v = 9'd98;   7'd17: v = 9'd104;  7'd18: v = 9'd109;  7'd19: v = 9'd115;
            7'd20: v = 9'd121;  7'd21: v = 9'd126;  7'd22: v = 9'd132;  7'd23: v = 9'd137;
            7'd24: v = 9'd142;  7'd25: v = 9'd147;  7'd26: v = 9'd152;  7'd27: v = 9'd157;
            7'd28: v = 9'd162;  7'd29: v = 9'd167;  7'd30: v = 9'd172;  7'd31: v = 9'd177;
            7'd32: v = 9'd181;  7'd33: v = 9'd185;  7'd34: v = 9'd190;  7'd35: v = 9'd194;
            7'd36: v = 9'd198;  7'd37: v = 9'd202;  7'd38: v = 9'd206;  7'd39: v = 9'd209;
            7'd40: v = 9'd213;  7'd41: v = 9'd216;  7'd42: v = 9'd220;  7'd43: v = 9'd223;
            7'd44: v = 9'd226;  7'd45: v = 9'd229;  7'd46: v = 9'd231;  7'd47: v = 9'd234;
            7'd48: v = 9'd237;  7'd49: v = 9'd239;  7'd50: v = 9'd241;  7'd51: v = 9'd243;
            7'd52: v = 9'd245;  7'd53: v = 9'd247;  7'd54: v = 9'd248;  7'd55: v = 9'd250;
            7'd56: v = 9'd251;  7'd57: v = 9'd252;  7'd58: v = 9'd253;  7'd59: v = 9'd254;
            7'd60: v = 9'd255;  7'd61: v = 9'd255;  7'd62: v = 9'd256;  7'd63: v = 9'd256;
            default: v = 9'd256;
        endcase
        return v;
    endfunction

    // Breath curve in 0..256: half of (sine + 256), sine in Q8 from the quarter table.
    function automatic logic [8:0] sine_half(input logic [7:0] p);
        logic [6:0] j;
        logic [8:0] v;
        logic [9:0] sum;
        j = p[6] ? (7'd64 - {1'b0, p[5:0]}) : {1'b0, p[5:0]};
        v = quarter_sine(j);
        sum = p[7] ? (10'd256 - {1'b0, v}) : (10'd256 + {1'b0, v});
        return sum[9:1];
    endfunction

    // Hue offset of each LED as a 16-bit fraction of the strip, built at elaboration.
    typedef logic [15:0] t_hue_tab [2**PIX_W];

    function automatic t_hue_tab hue_table();
        t_hue_tab t;
        for (int i = 0; i < 2**PIX_W; i++) begin
            t[i] = (i < NUM_LEDS) ? 16'((i << 16) / NUM_LEDS) : 16'd0;
        end
        return t;
    endfunction

    localparam t_hue_tab HUE_OFF = hue_table();

    // Level-meter mask: true when the LED stays lit.
    function automatic logic meter_lit(input logic [PIX_W-1:0] i, input logic [2:0] lvl);
        int p;
        int d;
        logic lit;
        lit = 1'b1;
        if (int'(i) < 2 * LEDS_PER_EAR) begin
            p = (int'(i) < LEDS_PER_EAR) ? int'(i) : int'(i) - LEDS_PER_EAR;
            d = LEDS_PER_EAR - 1 - p;
            if (p < d) d = p;
            lit = (d < int'(lvl));
        end
        return lit;
    endfunction

endpackage

>>> sv/lsaf_front.sv
// Front end: takes frame ticks, classifies the mode and works out phase and gain.
module lsaf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsaf_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_clock_ms,
    input  logic [8:0]     i_mouth_amount,
    input  logic [3:0]     i_mood_index,
    input  logic           i_bus_hold,
    output logic           o_push,
    input  logic           i_q_ready,
    output lsaf_pkg::t_job o_job
);
    import lsaf_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_CLS, ST_DIV, ST_GAIN, ST_LVL, ST_PUSH} t_state;
    typedef enum logic [1:0] {K_OFF, K_SOLID, K_BREATH, K_RAIN} t_kind;

    localparam int DIV_BITS  = 4;
    localparam int DIV_ITERS = 48 / DIV_BITS;

    // Holding register in front of the front sequencer.
    logic        r_hv;
    logic [31:0] r_hclk;
    logic [8:0]  r_hm;
    logic [3:0]  r_hmood;
    logic        r_hbus;

    t_state      r_state;
    logic [47:0] r_div;
    logic [15:0] r_rem;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic [8:0]  r_m;
    logic [3:0]  r_mood;
    logic [7:0]  r_bright;
    t_kind       r_kind;
    logic [23:0] r_color;
    logic [7:0]  r_floor;
    logic [14:0] r_per;
    logic [8:0]  r_gain;
    logic        r_meter;
    logic [2:0]  r_level;
    t_job        r_job;

    logic        take;
    assign o_ready = !r_hv;
    assign take    = (r_state == ST_IDLE) && r_hv;

    // Holding register load and release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_hv <= 1'b1;
        end else if (take) begin
            r_hv <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_hclk  <= i_clock_ms;
            r_hm    <= i_mouth_amount;
            r_hmood <= i_mood_index;
            r_hbus  <= i_bus_hold;
        end
    end

    // Classification of the latched tick.
    logic [16:0] mfac;
    logic [24:0] bprod;
    logic [7:0]  bright;
    t_mood       ent;
    t_kind       kind;
    logic [23:0] color;
    logic [7:0]  fl;
    logic [14:0] per;
    logic [2:0]  level;
    logic [9:0]  m10;

    always_comb begin
        mfac   = 17'd16384 + 17'(r_m) * 17'd192;
        bprod  = 25'(i_cfg.base_level) * 25'(mfac);
        bright = (i_cfg.mouth_link && !i_cfg.meter_select) ? bprod[23:16] : i_cfg.base_level;
        ent    = mood_entry((r_mood == MOOD_UNUSED) ? 4'd0 : r_mood);
        kind   = K_OFF;
        color  = i_cfg.base_rgb;
        fl     = 8'd38;
        per    = 15'd4000;
        if (i_cfg.mood_link) begin
            if (bright < 8'd110) bright = 8'd110;
            color = ent.rgb;
            fl    = ent.floor8;
            if (r_mood == MOOD_RAINBOW) begin
                kind = K_RAIN;
                per  = 15'd900;
            end else begin
                kind = K_BREATH;
                per  = ent.period;
            end
        end else begin
            case (i_cfg.anim_mode)
                MODE_SOLID:   kind = K_SOLID;
                MODE_BREATH:  kind = K_BREATH;
                MODE_RAINBOW: begin
                    kind = K_RAIN;
                    per  = 15'((i_cfg.rainbow_period == 8'd0) ? 8'd1 : i_cfg.rainbow_period)
                           * 15'd100;
                end
                default:      kind = K_OFF;
            endcase
        end
        // Meter level: count of odd thresholds reached.
        m10   = 10'(r_m) * 10'd10 >> 0;
        level = 3'd0;
        for (int k = 1; k <= 9; k += 2) begin
            if (13'(r_m) * 13'd10 >= 13'(256 * k)) level = level + 3'd1;
        end
    end

    // Restoring division of clock_ms * 65536 by the period, four bits a cycle.
    logic [47:0] div_n;
    logic [15:0] rem_n;
    logic [15:0] q_n;
    logic [15:0] trial;

    always_comb begin
        div_n = r_div;
        rem_n = r_rem;
        q_n   = r_q;
        for (int s = 0; s < DIV_BITS; s++) begin
            trial = {rem_n[14:0], div_n[47]};
            div_n = {div_n[46:0], 1'b0};
            if (trial >= {1'b0, r_per}) begin
                rem_n = trial - {1'b0, r_per};
                q_n   = {q_n[14:0], 1'b1};
            end else begin
                rem_n = trial;
                q_n   = {q_n[14:0], 1'b0};
            end
        end
    end

    // Breath gain and final channel gain.
    logic [8:0]  half;
    logic [17:0] gprod;
    logic [16:0] b2prod;
    logic [7:0]  jgain;

    always_comb begin
        half   = sine_half(r_q[15:8]);
        gprod  = 18'(half) * 18'(9'd256 - {1'b0, r_floor});
        b2prod = 17'(r_bright) * 17'(r_gain);
        case (r_kind)
            K_SOLID, K_RAIN: jgain = r_bright;
            K_BREATH:        jgain = b2prod[15:8];
            default:         jgain = 8'd0;
        endcase
    end

    // Front sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (take && !r_hbus) begin
                        r_state <= ST_CLS;
                    end
                    r_div  <= {r_hclk, 16'd0};
                    r_m    <= (r_hm > 9'd256) ? 9'd256 : r_hm;
                    r_mood <= r_hmood;
                end
                ST_CLS: begin
                    r_bright <= bright;
                    r_kind   <= kind;
                    r_color  <= color;
                    r_floor  <= fl;
                    r_per    <= per;
                    r_meter  <= i_cfg.mouth_link && i_cfg.meter_select;
                    r_level  <= level;
                    r_rem    <= 16'd0;
                    r_q      <= 16'd0;
                    r_cnt    <= 4'd0;
                    r_state  <= ST_DIV;
                end
                ST_DIV: begin
                    r_div <= div_n;
                    r_rem <= rem_n;
                    r_q   <= q_n;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(DIV_ITERS - 1)) r_state <= ST_GAIN;
                end
                ST_GAIN: begin
                    r_gain  <= 9'({1'b0, r_floor}) + gprod[16:8];
                    r_state <= ST_LVL;
                end
                ST_LVL: begin
                    r_job.rainbow <= (r_kind == K_RAIN);
                    r_job.color   <= r_color;
                    r_job.gain    <= jgain;
                    r_job.h0      <= r_q;
                    r_job.meter   <= r_meter;
                    r_job.level   <= r_level;
                    r_state       <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (i_q_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_push = (r_state == ST_PUSH) && i_q_ready;
    assign o_job  = r_job;

    logic unused_m10;
    assign unused_m10 = ^m10;
endmodule

>>> sv/lsaf_queue.sv
// Short job queue between the front end and the pixel engine.
module lsaf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsaf_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output lsaf_pkg::t_job o_job
);
    import lsaf_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_ready = (r_cnt != (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

>>> sv/lsaf_back.sv
// Pixel engine: walks the strip for one job and emits one pixel a cycle unless the output stalls.
module lsaf_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  lsaf_pkg::t_job            i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [lsaf_pkg::PIX_W-1:0] o_index,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic                      o_last
);
    import lsaf_pkg::*;

    localparam logic [PIX_W-1:0] LAST_IDX = PIX_W'(NUM_LEDS - 1);

    logic             r_v1, r_v2, r_v3;
    logic [PIX_W-1:0] r_idx;
    logic [PIX_W-1:0] r_i1, r_i2, r_i3;
    logic             r_l1, r_l2, r_l3;
    logic             r_lit1, r_lit2;
    logic [23:0]      r_c1;
    logic [7:0]       r_g1;
    logic [15:0]      r_pr, r_pg, r_pb;
    logic [7:0]       r_r3, r_g3, r_b3;

    logic advance, issue;
    assign advance = !r_v3 || i_ready;
    assign issue   = advance && i_q_valid;
    assign o_pop   = issue && (r_idx == LAST_IDX);

    // Hue to RGB for the current LED.
    logic [15:0] h;
    logic [18:0] x;
    logic [15:0] f;
    logic [23:0] rise_p;
    logic [24:0] fall_p;
    logic [7:0]  rise, fall;
    logic [23:0] hue_rgb;

    always_comb begin
        h      = i_job.h0 + HUE_OFF[r_idx];
        x      = {1'b0, h, 2'b00} + {2'b00, h, 1'b0};
        f      = x[15:0];
        rise_p = {f, 8'd0} - {8'd0, f};
        fall_p = {(17'h10000 - {1'b0, f}), 8'd0} - {8'd0, (17'h10000 - {1'b0, f})};
        rise   = rise_p[23:16];
        fall   = fall_p[23:16];
        case (x[18:16])
            3'd0:    hue_rgb = {8'd255, rise, 8'd0};
            3'd1:    hue_rgb = {fall, 8'd255, 8'd0};
            3'd2:    hue_rgb = {8'd0, 8'd255, rise};
            3'd3:    hue_rgb = {8'd0, fall, 8'd255};
            3'd4:    hue_rgb = {rise, 8'd0, 8'd255};
            default: hue_rgb = {8'd255, 8'd0, fall};
        endcase
    end

    // Division by 255 of a 16-bit product.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // Three-stage pixel pipeline that stalls as a whole on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_idx <= '0;
        end else if (advance) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (issue) r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
        if (advance) begin
            r_c1   <= i_job.rainbow ? hue_rgb : i_job.color;
            r_g1   <= i_job.gain;
            r_lit1 <= !i_job.meter || meter_lit(r_idx, i_job.level);
            r_i1   <= r_idx;
            r_l1   <= (r_idx == LAST_IDX);
            r_pr   <= 16'(r_c1[23:16]) * 16'(r_g1);
            r_pg   <= 16'(r_c1[15:8]) * 16'(r_g1);
            r_pb   <= 16'(r_c1[7:0]) * 16'(r_g1);
            r_lit2 <= r_lit1;
            r_i2   <= r_i1;
            r_l2   <= r_l1;
            r_r3   <= r_lit2 ? div255(r_pr) : 8'd0;
            r_g3   <= r_lit2 ? div255(r_pg) : 8'd0;
            r_b3   <= r_lit2 ? div255(r_pb) : 8'd0;
            r_i3   <= r_i2;
            r_l3   <= r_l2;
        end
    end

    assign o_valid = r_v3;
    assign o_index = r_i3;
    assign o_red   = r_r3;
    assign o_green = r_g3;
    assign o_blue  = r_b3;
    assign o_last  = r_l3;
endmodule

>>> sv/led_strip_animation_frame.sv
// LED strip animation: one frame tick in, one RGB pixel per LED out.
// A tick passes the holding register, the front sequencer, the job queue and the
// pixel pipeline before its first pixel is presented. The front end runs the 48-bit
// period divider for each tick, retiring four quotient bits a cycle. The pixel engine
// emits one pixel a cycle unless the output stalls, NUM_LEDS (18) pixels per frame.
// Synchronous active-low reset restores register defaults and empties the pipe.
module led_strip_animation_frame (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // clock_ms[31:0], mouth_amount[40:32], mood_index[44:41], zero fill
    input  logic [47:0] i_s_axis_tdata,
    // bus_hold[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_index[5:0], red_out[13:6], green_out[21:14], blue_out[29:22], zero fill
    output logic [31:0] o_m_axis_tdata,
    // final_pixel
    output logic        o_m_axis_tlast
);
    import lsaf_pkg::*;

    t_cfg r_cfg;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.anim_mode      <= MODE_OFF;
            r_cfg.base_rgb       <= 24'd0;
            r_cfg.base_level     <= 8'd26;
            r_cfg.mouth_link     <= 1'b0;
            r_cfg.meter_select   <= 1'b0;
            r_cfg.mood_link      <= 1'b1;
            r_cfg.rainbow_period <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ANIM_MODE:      r_cfg.anim_mode      <= i_cfg_wdata[1:0];
                CFG_BASE_RGB:       r_cfg.base_rgb       <= i_cfg_wdata;
                CFG_BASE_LEVEL:     r_cfg.base_level     <= i_cfg_wdata[7:0];
                CFG_MOUTH_LINK:     r_cfg.mouth_link     <= i_cfg_wdata[0];
                CFG_METER_SELECT:   r_cfg.meter_select   <= i_cfg_wdata[0];
                CFG_MOOD_LINK:      r_cfg.mood_link      <= i_cfg_wdata[0];
                CFG_RAINBOW_PERIOD: r_cfg.rainbow_period <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic push, q_ready, q_valid, pop;
    t_job f_job, q_job;
    logic [PIX_W-1:0] idx;
    logic [7:0] red, green, blue;

    lsaf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_clock_ms     (i_s_axis_tdata[31:0]),
        .i_mouth_amount (i_s_axis_tdata[40:32]),
        .i_mood_index   (i_s_axis_tdata[44:41]),
        .i_bus_hold     (i_s_axis_tuser),
        .o_push         (push),
        .i_q_ready      (q_ready),
        .o_job          (f_job)
    );

    lsaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    lsaf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_index   (idx),
        .o_red     (red),
        .o_green   (green),
        .o_blue    (blue),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'd0, blue, green, red, idx};

    logic unused_tdata;
    assign unused_tdata = ^i_s_axis_tdata[47:45];
endmodule

>>> sv/lsaf_checker.sv
// Port-level checker for the LED strip animation block, bound to the top level.
`include "led_strip_animation_frame_defines.svh"

module lsaf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] i_m_axis_tdata,
    input logic        i_m_axis_tlast
);
    import lsaf_pkg::*;

    localparam logic [PIX_W-1:0] LAST_IDX = PIX_W'(NUM_LEDS - 1);

    // A stalled pixel keeps its contents.
    `LSAF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata))

    // The frame marker sits on the last LED and only there.
    `LSAF_ASSERT_NOW(a_last, i_clk, i_rst_n, i_m_axis_tvalid, i_m_axis_tlast == (i_m_axis_tdata[PIX_W-1:0] == LAST_IDX))

    // Pixel positions stay on the strip.
    `LSAF_ASSERT_NOW(a_range, i_clk, i_rst_n, i_m_axis_tvalid, i_m_axis_tdata[PIX_W-1:0] <= LAST_IDX)
endmodule

bind led_strip_animation_frame lsaf_checker u_lsaf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);
